>>> rtl/etp_pkg.sv
// Shared types and constants for the engine topology table parser.
// No dependencies; the parser, scanner, top level and testbench import this package.
package etp_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_IGN  = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    localparam logic [31:0] BAD_WORD = 32'hffff_ffff;
    localparam int CHAIN_BIT = 31;
    localparam logic [1:0] POS_LAST = 2'd3;

    typedef struct packed {
        logic [5:0]  etype;
        logic [3:0]  inst;
        logic [11:0] addr;
        logic [4:0]  rst_bit;
        logic [13:0] runlist;
    } entry_t;

    localparam entry_t PEND_INIT = '{etype: 6'h3f, inst: 4'd0, addr: 12'd0,
                                     rst_bit: 5'd0, runlist: 14'd0};

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } store_wr_t;

    typedef struct packed {
        logic   done;
        logic   hit;
        entry_t data;
    } scan_res_t;

endpackage

>>> rtl/etp_parse.sv
// Table word parser: chain position, pending entry, entry count and flags.
// Depends on etp_pkg; issues writes into the entry store held by etp_scan.
module etp_parse
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       word_go,
    input  logic [31:0]                table_word,
    input  logic                       read_fault,
    input  logic                       first_word,
    input  logic                       last_word,
    output etp_pkg::store_wr_t         store_wr,
    output logic [etp_pkg::CNT_W-1:0]  count,
    output logic                       ready,
    output logic [1:0]                 status
);
    import etp_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ready_reg, ready_next;
    logic             abort_reg, abort_next;
    logic [1:0]       pos_reg, pos_next;
    entry_t           pend_reg, pend_next;
    logic [1:0]       status_reg, status_next;
    store_wr_t        wr;

    always_comb
    begin
        count_next  = count_reg;
        ready_next  = ready_reg;
        abort_next  = abort_reg;
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        status_next = ST_OK;
        wr          = '0;
        if (first_word)
        begin
            count_next = '0;
            ready_next = 1'b0;
            abort_next = 1'b0;
            pos_next   = 2'd0;
            pend_next  = PEND_INIT;
        end
        if (abort_next)
        begin
            status_next = ST_IGN;
        end
        else if (read_fault || table_word == BAD_WORD)
        begin
            abort_next  = 1'b1;
            status_next = ST_BAD;
        end
        else if (!(table_word == 32'd0 && pos_next == 2'd0))
        begin
            case (pos_next)
                2'd0:
                begin
                    pend_next.etype = table_word[29:24];
                    pend_next.inst  = table_word[19:16];
                end
                2'd1:
                begin
                    pend_next.addr    = table_word[23:12];
                    pend_next.rst_bit = table_word[4:0];
                end
                2'd2:
                begin
                    pend_next.runlist = table_word[23:10];
                end
                default:
                begin
                end
            endcase
            if (pos_next != POS_LAST)
                pos_next = pos_next + 2'd1;
            // A clear chain bit closes the entry; it is dropped once the table is full.
            if (!table_word[CHAIN_BIT])
            begin
                pos_next = 2'd0;
                if (count_next < MAX_CNT)
                begin
                    wr.en      = 1'b1;
                    wr.addr    = count_next[IDX_W-1:0];
                    wr.data    = pend_next;
                    count_next = count_next + CNT_W'(1);
                end
                pend_next = PEND_INIT;
            end
        end
        if (last_word)
            ready_next = (count_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ready_reg  <= 1'b0;
            abort_reg  <= 1'b0;
            pos_reg    <= 2'd0;
            pend_reg   <= PEND_INIT;
            status_reg <= ST_OK;
        end
        else if (word_go)
        begin
            count_reg  <= count_next;
            ready_reg  <= ready_next;
            abort_reg  <= abort_next;
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        store_wr    = wr;
        store_wr.en = wr.en && word_go;
    end

    assign count  = count_reg;
    assign ready  = ready_reg;
    assign status = status_reg;

endmodule

>>> rtl/etp_scan.sv
// Entry store and lookup scanner: one store read and one compare per cycle.
// Depends on etp_pkg; written by etp_parse, started by the top level.
module etp_scan
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [5:0]                 query_type,
    input  logic [3:0]                 query_inst,
    input  logic [etp_pkg::CNT_W-1:0]  count,
    input  etp_pkg::store_wr_t         store_wr,
    output etp_pkg::scan_res_t         res
);
    import etp_pkg::*;

    entry_t           mem [MAX_ENTRIES];
    entry_t           rd_data_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] issue_reg;
    logic             rd_vld_reg;
    logic             rd_last_reg;
    logic [5:0]       qtype_reg;
    logic [3:0]       qinst_reg;
    logic             can_issue;
    logic             match;
    logic             done;

    assign can_issue = busy_reg && (issue_reg < count);
    assign match     = (rd_data_reg.etype == qtype_reg) && (rd_data_reg.inst == qinst_reg);
    // The scan ends on the first match or after the last stored entry has been compared.
    assign done      = busy_reg && rd_vld_reg && (match || rd_last_reg);

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
            mem[store_wr.addr] <= store_wr.data;
        if (can_issue)
            rd_data_reg <= mem[issue_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qtype_reg <= query_type;
            qinst_reg <= query_inst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            issue_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg   <= 1'b1;
            issue_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rd_vld_reg  <= can_issue && !done;
            rd_last_reg <= (issue_reg + CNT_W'(1)) == count;
            if (can_issue)
                issue_reg <= issue_reg + CNT_W'(1);
            if (done)
                busy_reg <= 1'b0;
        end
    end

    always_comb
    begin
        res.done = done;
        res.hit  = match;
        res.data = rd_data_reg;
    end

endmodule

>>> rtl/engine_topology_table_parser_core.sv
// Engine topology table parser. A table word request registers its result in S_WORD. A lookup
// on a ready table scans the stored entries in S_SCAN up to the first match or the last entry;
// the single entry store read port is scanned once a cycle. A lookup on a table that is not
// ready answers in the cycle after acceptance. One request is in work at a time; the next is
// accepted the cycle after the result is taken. rst_n clears all control state asynchronously;
// the entry store is not cleared and only entries below the count are read.
module engine_topology_table_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] table_word,
    input  logic        read_fault,
    input  logic        first_word,
    input  logic        last_word,
    input  logic [5:0]  query_type,
    input  logic [3:0]  query_inst,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        found,
    output logic [23:0] runlist_field,
    output logic [23:0] engine_addr,
    output logic [31:0] reset_mask,
    output logic [5:0]  engine_count,
    output logic        table_ready
);
    import etp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WORD = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             accept;
    logic             word_go;
    logic             scan_go;
    store_wr_t        store_wr;
    logic [CNT_W-1:0] tbl_count;
    logic             tbl_ready;
    logic [1:0]       word_status;
    scan_res_t        scan_res;

    logic [1:0]  status_reg;
    logic        found_reg;
    logic [23:0] runlist_reg;
    logic [23:0] addr_reg;
    logic [31:0] mask_reg;
    logic [5:0]  count_reg;
    logic        ready_reg;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign word_go  = accept && !req_type;
    assign scan_go  = accept && req_type && tbl_ready;

    etp_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_go    (word_go),
        .table_word (table_word),
        .read_fault (read_fault),
        .first_word (first_word),
        .last_word  (last_word),
        .store_wr   (store_wr),
        .count      (tbl_count),
        .ready      (tbl_ready),
        .status     (word_status)
    );

    etp_scan u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_go),
        .query_type (query_type),
        .query_inst (query_inst),
        .count      (tbl_count),
        .store_wr   (store_wr),
        .res        (scan_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!req_type)
                        state_next = S_WORD;
                    else if (tbl_ready)
                        state_next = S_SCAN;
                    else
                        state_next = S_OUT;
                end
            end
            S_WORD:
            begin
                state_next = S_OUT;
            end
            S_SCAN:
            begin
                if (scan_res.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept && req_type && !tbl_ready)
        begin
            status_reg  <= ST_MISS;
            found_reg   <= 1'b0;
            runlist_reg <= '0;
            addr_reg    <= '0;
            mask_reg    <= '0;
            count_reg   <= 6'(tbl_count);
            ready_reg   <= tbl_ready;
        end
        else if (state_reg == S_WORD)
        begin
            status_reg  <= word_status;
            found_reg   <= 1'b0;
            runlist_reg <= '0;
            addr_reg    <= '0;
            mask_reg    <= '0;
            count_reg   <= 6'(tbl_count);
            ready_reg   <= tbl_ready;
        end
        else if (state_reg == S_SCAN && scan_res.done)
        begin
            status_reg  <= scan_res.hit ? ST_OK : ST_MISS;
            found_reg   <= scan_res.hit;
            runlist_reg <= scan_res.hit ? {scan_res.data.runlist, 10'd0} : 24'd0;
            addr_reg    <= scan_res.hit ? {scan_res.data.addr, 12'd0} : 24'd0;
            mask_reg    <= scan_res.hit ? (32'd1 << scan_res.data.rst_bit) : 32'd0;
            count_reg   <= 6'(tbl_count);
            ready_reg   <= tbl_ready;
        end
    end

    assign out_valid     = (state_reg == S_OUT);
    assign status        = status_reg;
    assign found         = found_reg;
    assign runlist_field = runlist_reg;
    assign engine_addr   = addr_reg;
    assign reset_mask    = mask_reg;
    assign engine_count  = count_reg;
    assign table_ready   = ready_reg;

endmodule

>>> rtl/etp_checker.sv
// Port-level checks for the engine topology table parser core.
// Depends only on the top level's ports; bound to it at the end of this file.
module etp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic        found,
    input  logic [23:0] runlist_field,
    input  logic [23:0] engine_addr,
    input  logic [31:0] reset_mask,
    input  logic [5:0]  engine_count,
    input  logic        table_ready
);

    // Only one request is in work: no new request is taken while a result waits.
    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while a result was pending");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(found)
            && $stable(reset_mask) && $stable(engine_count))
        else $error("stalled result changed");

    a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == 2'd0 && $onehot(reset_mask) && table_ready)
        else $error("matched lookup with inconsistent fields");

    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> runlist_field == 24'd0 && engine_addr == 24'd0
            && reset_mask == 32'd0)
        else $error("unmatched result carries entry data");

    a_ready_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_ready |-> engine_count != 6'd0)
        else $error("table ready with no entries");

endmodule

bind engine_topology_table_parser_core etp_checker u_etp_checker (.*);

>>> tb/engine_topology_table_parser_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for engine_topology_table_parser_core: directed rows, then random tables and noise.
// Depends on rtl/etp_pkg.sv and the core; an internal predictor supplies the expected replies where no row gives them.
module engine_topology_table_parser_core_tb;
    import etp_pkg::*;

    localparam logic REQ_WORD   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;
    localparam int   ITEM_TARGET = 950;
    localparam int   DRAIN_CYCLES = 40;

    typedef struct packed {
        logic        lookup;
        logic [31:0] word;
        logic        fault;
        logic        first;
        logic        last;
        logic [5:0]  qtype;
        logic [3:0]  qinst;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [23:0]      runlist;
        logic [23:0]      addr;
        logic [31:0]      mask;
        logic [CNT_W-1:0] count;
        logic             ready;
    } reply_t;

    typedef struct packed {
        req_t   req;
        logic   typed;
        reply_t want;
    } stim_row_t;

    localparam reply_t UNTYPED = '0;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_WORD;
    logic [31:0] table_word = '0;
    logic        read_fault = 1'b0;
    logic        first_word = 1'b0;
    logic        last_word = 1'b0;
    logic [5:0]  query_type = '0;
    logic [3:0]  query_inst = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        found;
    logic [23:0] runlist_field;
    logic [23:0] engine_addr;
    logic [31:0] reset_mask;
    logic [5:0]  engine_count;
    logic        table_ready;

    // Predictor state: a copy of the parser's table and chain tracking.
    entry_t           tbl_store [MAX_ENTRIES];
    logic [CNT_W-1:0] tbl_count = '0;
    logic             tbl_ready = 1'b0;
    logic             tbl_abort = 1'b0;
    logic [1:0]       chain_pos = '0;
    entry_t           open_entry = PEND_INIT;

    reply_t replies_due [$];
    reply_t due;
    int     mismatches = 0;
    int     sent = 0;
    int     lookups = 0;
    int     hits = 0;
    int     tables = 0;
    int     results_seen = 0;
    int     stall_left = 0;
    bit     in_burst = 1'b0;
    bit     out_burst = 1'b0;

    // Directed rows: reset state, field extremes, long chains, faults and the ignore phase.
    stim_row_t directed_rows [20] = '{
        '{'{REQ_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}, 1'b1,
          '{ST_MISS, 1'b0, 24'h0, 24'h0, 32'h0, 6'd0, 1'b0}},
        '{'{REQ_WORD, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 6'd0, 4'd0}, 1'b1,
          '{ST_OK, 1'b0, 24'h0, 24'h0, 32'h0, 6'd0, 1'b0}},
        '{'{REQ_WORD, 32'hBF0F_0000, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}, 1'b1,
          '{ST_OK, 1'b0, 24'h0, 24'h0, 32'h0, 6'd0, 1'b0}},
        '{'{REQ_WORD, 32'h80FF_F01F, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}, 1'b0, UNTYPED},
        '{'{REQ_WORD, 32'h80FF_FC00, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}, 1'b0, UNTYPED},
        '{'{REQ_WORD, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}, 1'b1,
          '{ST_OK, 1'b0, 24'h0, 24'h0, 32'h0, 6'd1, 1'b0}},
        '{'{REQ_WORD, 32'h0102_0000, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}, 1'b0, UNTYPED},
        '{'{REQ_WORD, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 6'd0, 4'd0}, 1'b1,
          '{ST_OK, 1'b0, 24'h0, 24'h0, 32'h0, 6'd2, 1'b1}},
        '{'{REQ_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 6'd63, 4'd15}, 1'b1,
          '{ST_OK, 1'b1, 24'hFFFC00, 24'hFFF000, 32'h8000_0000, 6'd2, 1'b1}},
        '{'{REQ_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd1, 4'd2}, 1'b1,
          '{ST_OK, 1'b1, 24'h0, 24'h0, 32'h0000_0001, 6'd2, 1'b1}},
        '{'{REQ_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}, 1'b1,
          '{ST_MISS, 1'b0, 24'h0, 24'h0, 32'h0, 6'd2, 1'b1}},
        '{'{REQ_WORD, 32'h1234_5678, 1'b1, 1'b0, 1'b0, 6'd0, 4'd0}, 1'b1,
          '{ST_BAD, 1'b0, 24'h0, 24'h0, 32'h0, 6'd2, 1'b1}},
        '{'{REQ_WORD, 32'h0500_0000, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}, 1'b1,
          '{ST_IGN, 1'b0, 24'h0, 24'h0, 32'h0, 6'd2, 1'b1}},
        '{'{REQ_WORD, 32'h0500_0000, 1'b0, 1'b0, 1'b1, 6'd0, 4'd0}, 1'b1,
          '{ST_IGN, 1'b0, 24'h0, 24'h0, 32'h0, 6'd2, 1'b1}},
        '{'{REQ_WORD, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 6'd0, 4'd0}, 1'b1,
          '{ST_BAD, 1'b0, 24'h0, 24'h0, 32'h0, 6'd0, 1'b0}},
        '{'{REQ_WORD, 32'h8000_0000, 1'b0, 1'b1, 1'b1, 6'd0, 4'd0}, 1'b1,
          '{ST_OK, 1'b0, 24'h0, 24'h0, 32'h0, 6'd0, 1'b0}},
        '{'{REQ_WORD, 32'h0000_1000, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}, 1'b0, UNTYPED},
        '{'{REQ_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}, 1'b1,
          '{ST_MISS, 1'b0, 24'h0, 24'h0, 32'h0, 6'd1, 1'b0}},
        '{'{REQ_WORD, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 6'd0, 4'd0}, 1'b1,
          '{ST_OK, 1'b0, 24'h0, 24'h0, 32'h0, 6'd1, 1'b1}},
        '{'{REQ_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0, 4'd0}, 1'b1,
          '{ST_OK, 1'b1, 24'h0, 24'h001000, 32'h0000_0001, 6'd1, 1'b1}}
    };

    engine_topology_table_parser_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .table_word    (table_word),
        .read_fault    (read_fault),
        .first_word    (first_word),
        .last_word     (last_word),
        .query_type    (query_type),
        .query_inst    (query_inst),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found         (found),
        .runlist_field (runlist_field),
        .engine_addr   (engine_addr),
        .reset_mask    (reset_mask),
        .engine_count  (engine_count),
        .table_ready   (table_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the reply to one accepted request and advances the table state.
    function automatic reply_t table_reply(req_t r);
        reply_t res;
        res = '0;
        if (r.lookup == REQ_LOOKUP)
        begin
            res.status = ST_MISS;
            if (tbl_ready)
            begin
                for (int i = 0; i < int'(tbl_count); i++)
                begin
                    if (tbl_store[i].etype == r.qtype && tbl_store[i].inst == r.qinst)
                    begin
                        res.status  = ST_OK;
                        res.found   = 1'b1;
                        res.runlist = {tbl_store[i].runlist, 10'd0};
                        res.addr    = {tbl_store[i].addr, 12'd0};
                        res.mask    = 32'd1 << tbl_store[i].rst_bit;
                        break;
                    end
                end
            end
        end
        else
        begin
            if (r.first)
            begin
                tbl_count  = '0;
                tbl_ready  = 1'b0;
                tbl_abort  = 1'b0;
                chain_pos  = '0;
                open_entry = PEND_INIT;
            end
            if (tbl_abort)
                res.status = ST_IGN;
            else if (r.fault || r.word == BAD_WORD)
            begin
                tbl_abort  = 1'b1;
                res.status = ST_BAD;
            end
            else if (!(r.word == 32'd0 && chain_pos == 2'd0))
            begin
                res.status = ST_OK;
                case (chain_pos)
                    2'd0:
                    begin
                        open_entry.etype = r.word[29:24];
                        open_entry.inst  = r.word[19:16];
                    end
                    2'd1:
                    begin
                        open_entry.addr    = r.word[23:12];
                        open_entry.rst_bit = r.word[4:0];
                    end
                    2'd2: open_entry.runlist = r.word[23:10];
                    default: ;
                endcase
                if (chain_pos != POS_LAST)
                    chain_pos = chain_pos + 2'd1;
                // A clear chain bit closes the entry; it is kept only while there is room.
                if (!r.word[CHAIN_BIT])
                begin
                    chain_pos = '0;
                    if (tbl_count < MAX_CNT)
                    begin
                        tbl_store[tbl_count] = open_entry;
                        tbl_count = tbl_count + 1'b1;
                    end
                    open_entry = PEND_INIT;
                end
            end
            if (r.last)
                tbl_ready = (tbl_count != '0);
        end
        res.count = tbl_count;
        res.ready = tbl_ready;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Presents one request, holds it until taken and records the reply it should cause.
    task automatic send_request(req_t r, logic typed, reply_t want);
        int gap;
        reply_t predicted;
        gap = in_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= r.lookup;
        table_word <= r.word;
        read_fault <= r.fault;
        first_word <= r.first;
        last_word  <= r.last;
        query_type <= r.qtype;
        query_inst <= r.qinst;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = table_reply(r);
        replies_due.push_back(typed ? want : predicted);
        sent++;
        if (r.lookup == REQ_LOOKUP)
        begin
            lookups++;
            if (predicted.found)
                hits++;
        end
    endtask

    // Types and instances are mostly drawn from a small set so that lookups find entries.
    function automatic logic [5:0] pick_type();
        return ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 3)) : 6'($urandom);
    endfunction

    function automatic logic [3:0] pick_inst();
        return ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
    endfunction

    function automatic req_t lookup_req();
        req_t r;
        r = '0;
        r.lookup = REQ_LOOKUP;
        r.word   = $urandom;
        r.fault  = 1'($urandom);
        r.first  = 1'($urandom);
        r.last   = 1'($urandom);
        r.qtype  = pick_type();
        r.qinst  = pick_inst();
        return r;
    endfunction

    // A table with random content, an occasional bad word and lookups in between and afterwards.
    task automatic send_table();
        int n_ent;
        int clen;
        logic opening;
        req_t r;
        n_ent   = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
        opening = ($urandom_range(0, 9) != 0);
        tables++;
        for (int e = 0; e < n_ent; e++)
        begin
            r = '0;
            r.lookup = REQ_WORD;
            if ($urandom_range(0, 4) == 0)
            begin
                r.first = opening;
                opening = 1'b0;
                send_request(r, 1'b0, UNTYPED);
            end
            clen = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 5) : $urandom_range(1, 3);
            for (int k = 0; k < clen; k++)
            begin
                r = '0;
                r.lookup = REQ_WORD;
                r.qtype  = 6'($urandom);
                r.qinst  = 4'($urandom);
                r.word   = $urandom;
                if (k == 0)
                begin
                    r.word[29:24] = pick_type();
                    r.word[19:16] = pick_inst();
                end
                r.word[CHAIN_BIT] = (k < clen - 1);
                if ($urandom_range(0, 79) == 0)
                begin
                    if ($urandom_range(0, 1) == 1)
                        r.fault = 1'b1;
                    else
                        r.word = BAD_WORD;
                end
                r.first = opening;
                opening = 1'b0;
                r.last  = (e == n_ent - 1) && (k == clen - 1);
                send_request(r, 1'b0, UNTYPED);
                if ($urandom_range(0, 14) == 0)
                    send_request(lookup_req(), 1'b0, UNTYPED);
            end
        end
        repeat ($urandom_range(2, 8)) send_request(lookup_req(), 1'b0, UNTYPED);
    endtask

    // Unstructured requests: stray first and last marks, faults, gaps and lookups.
    task automatic send_noise();
        req_t r;
        repeat ($urandom_range(8, 24))
        begin
            r.lookup = ($urandom_range(0, 3) == 0) ? REQ_LOOKUP : REQ_WORD;
            case ($urandom_range(0, 9))
                0: r.word = 32'd0;
                1: r.word = BAD_WORD;
                default: r.word = $urandom;
            endcase
            r.fault = ($urandom_range(0, 19) == 0);
            r.first = ($urandom_range(0, 9) == 0);
            r.last  = ($urandom_range(0, 9) == 0);
            r.qtype = 6'($urandom);
            r.qinst = 4'($urandom);
            send_request(r, 1'b0, UNTYPED);
        end
    endtask

    // Reply side: check each accepted reply, then hold off for a random number of cycles unless in an output burst.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            if (replies_due.size() == 0)
                report_mismatch("reply with no request outstanding", 32'(status), 32'd0);
            else
            begin
                due = replies_due.pop_front();
                if (status !== due.status)
                    report_mismatch("status", 32'(status), 32'(due.status));
                if (found !== due.found)
                    report_mismatch("found", 32'(found), 32'(due.found));
                if (runlist_field !== due.runlist)
                    report_mismatch("runlist_field", 32'(runlist_field), 32'(due.runlist));
                if (engine_addr !== due.addr)
                    report_mismatch("engine_addr", 32'(engine_addr), 32'(due.addr));
                if (reset_mask !== due.mask)
                    report_mismatch("reset_mask", reset_mask, due.mask);
                if (engine_count !== due.count)
                    report_mismatch("engine_count", 32'(engine_count), 32'(due.count));
                if (table_ready !== due.ready)
                    report_mismatch("table_ready", 32'(table_ready), 32'(due.ready));
            end
            stall_left = out_burst ? 0 : $urandom_range(0, 10);
        end
        else if (stall_left > 0)
            stall_left--;
        out_stall <= (stall_left != 0);
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        while (sent < ITEM_TARGET)
        begin
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8)
                send_table();
            else
                send_noise();
        end
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d requests over %0d random tables: %0d lookups, %0d of them hits.",
                 sent, tables, lookups, hits);
        $display("Checked %0d replies, %0d field mismatches.", results_seen, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Timed out with %0d replies still outstanding.", replies_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
